/* src/bdmeq_pkg.sv */
// ----------------------------------------------------------------------------
// bdmeq_pkg
// Types, command codes and constants shared by the backdoor pointer port.
// ----------------------------------------------------------------------------
package bdmeq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 1024;

	localparam logic [31:0] PORT_MAGIC   = 32'h564D_5868;
	localparam logic [31:0] DEV_VERSION  = 32'h3442_554A;
	localparam logic [31:0] SUB_READ_ID  = 32'h4541_4552;
	localparam logic [31:0] SUB_DISABLE  = 32'h0000_00F5;
	localparam logic [31:0] SUB_RELATIVE = 32'h4C45_5252;
	localparam logic [31:0] SUB_ABSOLUTE = 32'h5342_4152;
	localparam logic [31:0] RAM_TAG      = 32'h0000_1177;
	localparam logic [31:0] VERSION_NUM  = 32'd6;
	localparam logic [31:0] MEM_SIZE_RST = 32'h0800_0000;
	localparam logic [31:0] MAX_READ     = 32'd6;

	localparam logic [15:0] CMD_VERSION = 16'h000A;
	localparam logic [15:0] CMD_RAMSIZE = 16'h0014;
	localparam logic [15:0] CMD_DATA    = 16'd39;
	localparam logic [15:0] CMD_STATUS  = 16'd40;
	localparam logic [15:0] CMD_SUB     = 16'd41;

	localparam logic CMD_HOST_EVENT  = 1'b0;
	localparam logic CMD_PORT_ACCESS = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [31:0]        reg_a;
		logic [31:0]        reg_b;
		logic [31:0]        reg_c;
		logic [31:0]        reg_d;
		logic [31:0]        reg_si;
		logic [31:0]        reg_di;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] wheel;
		logic [2:0]         button_bits;
	} bdmeq_in_t;

	typedef struct packed {
		logic [31:0] out_a;
		logic [31:0] out_b;
		logic [31:0] out_c;
		logic [31:0] out_d;
		logic [31:0] out_si;
		logic [31:0] out_di;
		logic        event_notify;
	} bdmeq_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PUSH,
		ST_READ,
		ST_DRAIN,
		ST_FIN
	} bdmeq_state_t;

endpackage

/* src/bdmeq_store.sv */
// ----------------------------------------------------------------------------
// bdmeq_store
// Word queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdmeq_store #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/bdmeq_ctrl.sv */
// ----------------------------------------------------------------------------
// bdmeq_ctrl
// Command decode, queue pointers, device flags and the store sequencer.
// ----------------------------------------------------------------------------
module bdmeq_ctrl
	import bdmeq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int unsigned AW          = $clog2(QUEUE_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  bdmeq_in_t     in_word,
	output logic          done,
	output bdmeq_out_t    out_word,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [31:0]   mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [31:0]   mem_rdata
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW:0] DEPTH_W = (CW+1)'(QUEUE_DEPTH);
	localparam logic [AW:0] DEPTH_A = (AW+1)'(QUEUE_DEPTH);

	bdmeq_state_t state_q, state_d;

	bdmeq_in_t    in_q;
	logic [31:0]  r_q [6];
	logic         notify_q;
	logic [1:0]   push_idx_q;
	logic [2:0]   rd_idx_q;
	logic [2:0]   rd_num_q;
	logic         rd_valid_s1;
	logic [2:0]   rd_idx_s1;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          error_q;
	logic          enabled_q;
	logic          absolute_q;
	logic [31:0]   mem_size_q;

	logic          done_q;
	bdmeq_out_t    out_q;

	logic [CW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic [AW:0]   head_inc;
	logic [AW-1:0] head_next;
	logic          room4;
	logic          room1;
	logic          magic_ok;
	logic          read_bad;
	logic          is_read_id;
	logic          read_last;
	logic [31:0]   btn_word;
	logic [31:0]   x_word;
	logic [31:0]   y_word;

	// tail = (head + count) mod depth, sum stays below twice the depth
	assign tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
	assign tail      = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
	assign head_inc  = (AW+1)'(head_q) + (AW+1)'(1);
	assign head_next = (head_inc == DEPTH_A) ? '0 : AW'(head_inc);

	assign room4      = ((CW+1)'(count_q) + (CW+1)'(4)) <= DEPTH_W;
	assign room1      = (CW+1)'(count_q) < DEPTH_W;
	assign magic_ok   = in_q.reg_a == PORT_MAGIC;
	assign read_bad   = (in_q.reg_b == 32'd0) || (in_q.reg_b > MAX_READ)
	                    || (in_q.reg_b > 32'(count_q));
	assign is_read_id = magic_ok && (in_q.reg_c[15:0] == CMD_SUB)
	                    && (in_q.reg_b == SUB_READ_ID) && room1;
	assign read_last  = rd_idx_q == (rd_num_q - 3'd1);

	assign btn_word = {26'd0, in_q.button_bits[0], in_q.button_bits[1],
	                   in_q.button_bits[2], 3'd0};
	assign x_word   = absolute_q ? {in_q.move_x[30:0], 1'b0} : in_q.move_x;
	assign y_word   = absolute_q ? {in_q.move_y[30:0], 1'b0} : in_q.move_y;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_FIN;
				if (in_q.cmd == CMD_HOST_EVENT) begin
					if (enabled_q && room4) begin
						state_d = ST_PUSH;
					end
				end else if (magic_ok && (in_q.reg_c[15:0] == CMD_DATA) && !read_bad) begin
					state_d = ST_READ;
				end
			end
			ST_PUSH: begin
				if (push_idx_q == 2'd3) begin
					state_d = ST_FIN;
				end
			end
			ST_READ: begin
				if (read_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy      = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = tail;
		mem_wdata = DEV_VERSION;
		mem_re    = 1'b0;
		mem_raddr = head_q;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_EXEC: begin
				mem_we = (in_q.cmd != CMD_HOST_EVENT) && is_read_id;
			end
			ST_PUSH: begin
				mem_we = 1'b1;
				case (push_idx_q)
					2'd0:    mem_wdata = btn_word;
					2'd1:    mem_wdata = x_word;
					2'd2:    mem_wdata = y_word;
					default: mem_wdata = in_q.wheel;
				endcase
			end
			ST_READ:  mem_re = 1'b1;
			ST_DRAIN: ;
			ST_FIN:   ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			done_q      <= state_q == ST_FIN;
			rd_valid_s1 <= state_q == ST_READ;
		end
	end

	// queue pointers and device flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			error_q    <= 1'b1;
			enabled_q  <= 1'b0;
			absolute_q <= 1'b0;
			mem_size_q <= MEM_SIZE_RST;
		end else begin
			if (cfg_we) begin
				mem_size_q <= cfg_wdata;
			end
			if (state_q == ST_PUSH) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_READ) begin
				head_q  <= head_next;
				count_q <= count_q - CW'(1);
			end
			if (state_q == ST_EXEC && in_q.cmd != CMD_HOST_EVENT && magic_ok) begin
				if (in_q.reg_c[15:0] == CMD_SUB) begin
					if (in_q.reg_b == SUB_DISABLE) begin
						error_q   <= 1'b1;
						enabled_q <= 1'b0;
					end else if (in_q.reg_b == SUB_READ_ID) begin
						if (room1) begin
							count_q <= count_q + CW'(1);
							error_q <= 1'b0;
						end
					end else if (in_q.reg_b == SUB_RELATIVE || in_q.reg_b == SUB_ABSOLUTE) begin
						if (!error_q) begin
							absolute_q <= in_q.reg_b == SUB_ABSOLUTE;
							enabled_q  <= 1'b1;
						end
					end
				end else if (in_q.reg_c[15:0] == CMD_DATA && read_bad) begin
					error_q   <= 1'b1;
					enabled_q <= 1'b0;
				end
			end
		end
	end

	// working register file of one access
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					in_q   <= in_word;
					r_q[0] <= in_word.reg_a;
					r_q[1] <= in_word.reg_b;
					r_q[2] <= in_word.reg_c;
					r_q[3] <= in_word.reg_d;
					r_q[4] <= in_word.reg_si;
					r_q[5] <= in_word.reg_di;
				end
			end
			ST_EXEC: begin
				notify_q   <= (in_q.cmd == CMD_HOST_EVENT) && enabled_q && room4;
				push_idx_q <= 2'd0;
				rd_idx_q   <= 3'd0;
				rd_num_q   <= in_q.reg_b[2:0];
				if (in_q.cmd == CMD_HOST_EVENT) begin
					for (int i = 0; i < 6; i++) begin
						r_q[i] <= 32'd0;
					end
				end else if (magic_ok) begin
					unique case (in_q.reg_c[15:0])
						CMD_VERSION: begin
							r_q[0] <= VERSION_NUM;
							r_q[1] <= PORT_MAGIC;
						end
						CMD_RAMSIZE: begin
							r_q[0] <= mem_size_q;
							r_q[1] <= RAM_TAG;
						end
						CMD_STATUS: begin
							r_q[0] <= {error_q ? 16'hFFFF : 16'h0000, 16'(count_q)};
						end
						default: ;
					endcase
				end
			end
			ST_PUSH: push_idx_q <= push_idx_q + 2'd1;
			ST_READ: rd_idx_q <= rd_idx_q + 3'd1;
			default: ;
		endcase
		// read data arrives from the store in the cycle after its address
		if (rd_valid_s1) begin
			r_q[rd_idx_s1] <= mem_rdata;
		end
		if (state_q == ST_FIN) begin
			out_q.out_a        <= r_q[0];
			out_q.out_b        <= r_q[1];
			out_q.out_c        <= r_q[2];
			out_q.out_d        <= r_q[3];
			out_q.out_si       <= r_q[4];
			out_q.out_di       <= r_q[5];
			out_q.event_notify <= notify_q;
		end
	end

	assign done     = done_q;
	assign out_word = out_q;

endmodule

/* src/backdoor_mouse_event_queue_core.sv */
// ----------------------------------------------------------------------------
// backdoor_mouse_event_queue_core
// Backdoor pointer port: guest register commands and a host event word queue.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// out_word for exactly one cycle with done high, and must be taken then. The
// block works on one item at a time. A simple port access passes through an
// execute and a finish state while busy is high; a host event that is queued
// also writes its four words to the store, one per cycle, and a data read of n
// words reads one word from the store per cycle and then waits in a drain state
// for the registered read data before it finishes. The word store needs no
// clearing after reset; the memory size register may be written at any time
// while idle.
module backdoor_mouse_event_queue_core
	import bdmeq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  bdmeq_in_t  in_word,
	output logic       done,
	output bdmeq_out_t out_word,
	input  logic       cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	bdmeq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.AW          (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_word   (in_word),
		.done      (done),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	bdmeq_store #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* src/bdmeq_checker.sv */
// ----------------------------------------------------------------------------
// bdmeq_checker
// Port-level checks of the backdoor pointer port, bound to the top level.
// ----------------------------------------------------------------------------
module bdmeq_checker
	import bdmeq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input bdmeq_out_t out_word
);

	// a result only shows once the block is free again
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result word while busy");

	// an accepted word always takes the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("accept did not raise busy");

	// one result per word, and never right after an accept
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> !done)
		else $error("result right after accept");

	// a queued host event returns cleared registers
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_word.event_notify) |->
		(out_word.out_a == 32'd0 && out_word.out_b == 32'd0 && out_word.out_c == 32'd0
		 && out_word.out_d == 32'd0 && out_word.out_si == 32'd0
		 && out_word.out_di == 32'd0))
		else $error("host event result not cleared");

endmodule

bind backdoor_mouse_event_queue_core bdmeq_checker u_bdmeq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.out_word (out_word)
);
